@@ design/ets_pkg.sv @@
// Shared types, constants and helpers for the expression token scanner.
// Used by ets_scan, ets_queue and expression_token_scanner_top; no dependencies.
package ets_pkg;

    localparam int NAME_BUFFER = 64;
    localparam int POS_WIDTH   = 16;
    localparam int NLEN_W      = $clog2(NAME_BUFFER);
    localparam int TOK_W       = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    localparam logic [7:0] BYTE_END  = 8'h00;
    localparam logic [7:0] MARK_B0   = 8'hEF;
    localparam logic [7:0] MARK_B1   = 8'hBB;
    localparam logic [7:0] MARK_B2   = 8'hBF;
    localparam logic [7:0] HIGH_BYTE = 8'h80;

    localparam logic [3:0] KIND_END     = 4'd0;
    localparam logic [3:0] KIND_NUMBER  = 4'd1;
    localparam logic [3:0] KIND_NAME    = 4'd2;
    localparam logic [3:0] KIND_PLUS    = 4'd3;
    localparam logic [3:0] KIND_MINUS   = 4'd4;
    localparam logic [3:0] KIND_STAR    = 4'd5;
    localparam logic [3:0] KIND_SLASH   = 4'd6;
    localparam logic [3:0] KIND_CARET   = 4'd7;
    localparam logic [3:0] KIND_LPAREN  = 4'd8;
    localparam logic [3:0] KIND_RPAREN  = 4'd9;
    localparam logic [3:0] KIND_BANG    = 4'd10;
    localparam logic [3:0] KIND_COMMA   = 4'd11;
    localparam logic [3:0] KIND_EQUAL   = 4'd12;
    localparam logic [3:0] KIND_INVALID = 4'd13;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_DIGITS = 3'd1;
    localparam logic [2:0] ERR_BARE_EXP  = 3'd2;
    localparam logic [2:0] ERR_LONG_NAME = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd4;

    typedef enum logic [8:0] {
        MODE_IDLE     = 9'b000000001,
        MODE_INT      = 9'b000000010,
        MODE_DOT      = 9'b000000100,
        MODE_FRAC     = 9'b000001000,
        MODE_EXP_E    = 9'b000010000,
        MODE_EXP_SIGN = 9'b000100000,
        MODE_EXP_DIG  = 9'b001000000,
        MODE_NAME     = 9'b010000000,
        MODE_ERROR    = 9'b100000000
    } mode_t;

    typedef enum logic [3:0] {
        MARK_NONE = 4'b0001,
        MARK_EF   = 4'b0010,
        MARK_EFBB = 4'b0100,
        MARK_DONE = 4'b1000
    } mark_t;

    typedef struct packed {
        logic [3:0]       kind;
        logic [2:0]       code;
        logic [TOK_W-1:0] start;
        logic [TOK_W-1:0] length;
        logic             last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } scan_res_t;

    function automatic logic [TOK_W-1:0] cap_pos(input logic [POS_WIDTH-1:0] v);
        logic [TOK_W-1:0] r;
        if (POS_WIDTH > TOK_W && v > POS_WIDTH'({TOK_W{1'b1}})) begin
            r = {TOK_W{1'b1}};
        end else begin
            r = TOK_W'(v);
        end
        return r;
    endfunction

    function automatic token_t mk_tok(input logic [3:0] kind, input logic [2:0] code,
                                      input logic [TOK_W-1:0] start,
                                      input logic [TOK_W-1:0] length, input logic last);
        token_t t;
        t.kind   = kind;
        t.code   = code;
        t.start  = start;
        t.length = length;
        t.last   = last;
        return t;
    endfunction

    // KIND_INVALID when the byte is no operator
    function automatic logic [3:0] op_kind(input logic [7:0] b);
        logic [3:0] k;
        unique case (b)
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h5E:   k = KIND_CARET;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h21:   k = KIND_BANG;
            8'h2C:   k = KIND_COMMA;
            8'h3D:   k = KIND_EQUAL;
            default: k = KIND_INVALID;
        endcase
        return k;
    endfunction

endpackage

@@ design/ets_scan.sv @@
// Scanner core: mode, position and mark registers plus the per-byte next-state
// and token logic. Depends on ets_pkg.
module ets_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic [7:0]        byte_in,
    output ets_pkg::scan_res_t res
);

    ets_pkg::mode_t                    mode_reg, mode_next;
    ets_pkg::mark_t                    mark_reg, mark_next;
    logic [ets_pkg::POS_WIDTH-1:0]     pos_reg, pos_next;
    logic [ets_pkg::POS_WIDTH-1:0]     pend_reg, pend_next;
    logic [ets_pkg::NLEN_W-1:0]        nlen_reg, nlen_next;

    logic [ets_pkg::POS_WIDTH-1:0]     pos_inc;
    logic [ets_pkg::POS_WIDTH-1:0]     num_len;
    logic is_dig, is_alpha, is_space, is_dot, is_e, is_sign, is_end;
    logic name_first, name_part, name_full;
    logic [3:0] op;

    assign pos_inc    = (pos_reg == ets_pkg::POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign num_len    = pos_reg - pend_reg;
    assign is_dig     = byte_in >= 8'h30 && byte_in <= 8'h39;
    assign is_alpha   = (byte_in >= 8'h41 && byte_in <= 8'h5A) ||
                        (byte_in >= 8'h61 && byte_in <= 8'h7A);
    assign is_space   = (byte_in >= 8'h09 && byte_in <= 8'h0D) || byte_in == 8'h20;
    assign is_dot     = byte_in == 8'h2E;
    assign is_e       = byte_in == 8'h65 || byte_in == 8'h45;
    assign is_sign    = byte_in == 8'h2B || byte_in == 8'h2D;
    assign is_end     = byte_in == ets_pkg::BYTE_END;
    assign name_first = byte_in == 8'h5F || is_alpha || byte_in >= ets_pkg::HIGH_BYTE;
    assign name_part  = name_first || is_dig;
    assign name_full  = nlen_reg == ets_pkg::NLEN_W'(ets_pkg::NAME_BUFFER - 1);
    assign op         = ets_pkg::op_kind(byte_in);

    always_comb begin
        logic            skip;
        logic            start;
        logic            fail;
        logic [2:0]      fail_code;
        logic            a_v;
        logic            b_v;
        ets_pkg::token_t a_tok;
        ets_pkg::token_t b_tok;

        mode_next = mode_reg;
        mark_next = mark_reg;
        pos_next  = pos_reg;
        pend_next = pend_reg;
        nlen_next = nlen_reg;
        skip      = 1'b0;
        start     = 1'b0;
        fail      = 1'b0;
        fail_code = ets_pkg::ERR_NONE;
        a_v       = 1'b0;
        b_v       = 1'b0;
        a_tok     = '0;
        b_tok     = '0;

        unique case (mark_reg)
            ets_pkg::MARK_NONE: begin
                if (byte_in == ets_pkg::MARK_B0) begin
                    mark_next = ets_pkg::MARK_EF;
                    mode_next = ets_pkg::MODE_NAME;
                    pend_next = pos_reg;
                    nlen_next = ets_pkg::NLEN_W'(1);
                    pos_next  = pos_inc;
                    skip      = 1'b1;
                end else begin
                    mark_next = ets_pkg::MARK_DONE;
                end
            end
            ets_pkg::MARK_EF: begin
                mark_next = (byte_in == ets_pkg::MARK_B1) ? ets_pkg::MARK_EFBB
                                                          : ets_pkg::MARK_DONE;
            end
            ets_pkg::MARK_EFBB: begin
                mark_next = ets_pkg::MARK_DONE;
                if (byte_in == ets_pkg::MARK_B2) begin
                    mode_next = ets_pkg::MODE_IDLE;
                    nlen_next = '0;
                    pos_next  = pos_inc;
                    skip      = 1'b1;
                end
            end
            default: ;
        endcase

        if (!skip) begin
            unique case (mode_reg)
                ets_pkg::MODE_INT, ets_pkg::MODE_FRAC: begin
                    if (is_dig) begin
                        pos_next = pos_inc;
                    end else if (is_dot && mode_reg == ets_pkg::MODE_INT) begin
                        mode_next = ets_pkg::MODE_FRAC;
                        pos_next  = pos_inc;
                    end else if (is_e) begin
                        mode_next = ets_pkg::MODE_EXP_E;
                        pos_next  = pos_inc;
                    end else begin
                        a_v   = 1'b1;
                        a_tok = ets_pkg::mk_tok(ets_pkg::KIND_NUMBER, ets_pkg::ERR_NONE,
                                                ets_pkg::cap_pos(pend_reg),
                                                ets_pkg::cap_pos(num_len), 1'b0);
                        start = 1'b1;
                    end
                end
                ets_pkg::MODE_DOT: begin
                    if (is_dig) begin
                        mode_next = ets_pkg::MODE_FRAC;
                        pos_next  = pos_inc;
                    end else begin
                        fail      = 1'b1;
                        fail_code = ets_pkg::ERR_NO_DIGITS;
                    end
                end
                ets_pkg::MODE_EXP_E, ets_pkg::MODE_EXP_SIGN: begin
                    if (is_sign && mode_reg == ets_pkg::MODE_EXP_E) begin
                        mode_next = ets_pkg::MODE_EXP_SIGN;
                        pos_next  = pos_inc;
                    end else if (is_dig) begin
                        mode_next = ets_pkg::MODE_EXP_DIG;
                        pos_next  = pos_inc;
                    end else begin
                        fail      = 1'b1;
                        fail_code = ets_pkg::ERR_BARE_EXP;
                    end
                end
                ets_pkg::MODE_EXP_DIG: begin
                    if (is_dig) begin
                        pos_next = pos_inc;
                    end else begin
                        a_v   = 1'b1;
                        a_tok = ets_pkg::mk_tok(ets_pkg::KIND_NUMBER, ets_pkg::ERR_NONE,
                                                ets_pkg::cap_pos(pend_reg),
                                                ets_pkg::cap_pos(num_len), 1'b0);
                        start = 1'b1;
                    end
                end
                ets_pkg::MODE_NAME: begin
                    if (name_part) begin
                        if (name_full) begin
                            fail      = 1'b1;
                            fail_code = ets_pkg::ERR_LONG_NAME;
                        end else begin
                            nlen_next = nlen_reg + 1'b1;
                            pos_next  = pos_inc;
                        end
                    end else begin
                        a_v       = 1'b1;
                        a_tok     = ets_pkg::mk_tok(ets_pkg::KIND_NAME, ets_pkg::ERR_NONE,
                                                    ets_pkg::cap_pos(pend_reg),
                                                    ets_pkg::TOK_W'(nlen_reg), 1'b0);
                        nlen_next = '0;
                        start     = 1'b1;
                    end
                end
                ets_pkg::MODE_ERROR: begin
                    if (is_end) begin
                        mode_next = ets_pkg::MODE_IDLE;
                        mark_next = ets_pkg::MARK_NONE;
                        pos_next  = '0;
                        pend_next = '0;
                        nlen_next = '0;
                    end else begin
                        pos_next = pos_inc;
                    end
                end
                default: start = 1'b1;
            endcase
        end

        if (fail) begin
            a_v   = 1'b1;
            a_tok = ets_pkg::mk_tok(ets_pkg::KIND_INVALID, fail_code,
                                    ets_pkg::cap_pos(pend_reg), '0, 1'b1);
        end

        if (start) begin
            if (is_end) begin
                b_v   = 1'b1;
                b_tok = ets_pkg::mk_tok(ets_pkg::KIND_END, ets_pkg::ERR_NONE,
                                        ets_pkg::cap_pos(pos_reg), '0, 1'b1);
            end else begin
                pend_next = pos_reg;
                pos_next  = pos_inc;
                if (is_space) begin
                    mode_next = ets_pkg::MODE_IDLE;
                end else if (is_dig) begin
                    mode_next = ets_pkg::MODE_INT;
                end else if (is_dot) begin
                    mode_next = ets_pkg::MODE_DOT;
                end else if (name_first) begin
                    mode_next = ets_pkg::MODE_NAME;
                    nlen_next = ets_pkg::NLEN_W'(1);
                end else if (op == ets_pkg::KIND_INVALID) begin
                    b_v       = 1'b1;
                    b_tok     = ets_pkg::mk_tok(ets_pkg::KIND_INVALID, ets_pkg::ERR_UNKNOWN,
                                                ets_pkg::cap_pos(pos_reg), '0, 1'b1);
                    mode_next = ets_pkg::MODE_ERROR;
                end else begin
                    b_v       = 1'b1;
                    b_tok     = ets_pkg::mk_tok(op, ets_pkg::ERR_NONE,
                                                ets_pkg::cap_pos(pos_reg), '0, 1'b0);
                    mode_next = ets_pkg::MODE_IDLE;
                end
            end
        end

        // terminator while failing, or end token: back to reset state
        if ((fail || start) && is_end) begin
            mode_next = ets_pkg::MODE_IDLE;
            mark_next = ets_pkg::MARK_NONE;
            pos_next  = '0;
            pend_next = '0;
            nlen_next = '0;
        end else if (fail) begin
            mode_next = ets_pkg::MODE_ERROR;
            pos_next  = pos_inc;
        end

        res.count = 2'(a_v) + 2'(b_v);
        res.tok0  = a_v ? a_tok : b_tok;
        res.tok1  = b_tok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ets_pkg::MODE_IDLE;
            mark_reg <= ets_pkg::MARK_NONE;
            pos_reg  <= '0;
            pend_reg <= '0;
            nlen_reg <= '0;
        end else if (take) begin
            mode_reg <= mode_next;
            mark_reg <= mark_next;
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
            nlen_reg <= nlen_next;
        end
    end

endmodule

@@ design/ets_queue.sv @@
// Small token queue: takes up to two tokens per cycle, hands out one while out_ready is high.
// Depends on ets_pkg.
module ets_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ets_pkg::scan_res_t push_res,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output ets_pkg::token_t    out_tok
);

    ets_pkg::token_t               mem_reg [ets_pkg::QUEUE_DEPTH];
    logic [ets_pkg::QPTR_W-1:0]    wr_reg, rd_reg;
    logic [ets_pkg::QCNT_W-1:0]    cnt_reg;
    logic [1:0]                    n_push;
    logic                          pop;
    logic [ets_pkg::QPTR_W-1:0]    wr_plus1;

    assign n_push    = push ? push_res.count : 2'd0;
    assign pop       = out_valid && out_ready;
    assign wr_plus1  = wr_reg + 1'b1;
    assign in_ready  = cnt_reg <= ets_pkg::QCNT_W'(ets_pkg::QUEUE_DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign out_tok   = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            mem_reg[wr_reg] <= push_res.tok0;
        end
        if (n_push == 2'd2) begin
            mem_reg[wr_plus1] <= push_res.tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + ets_pkg::QPTR_W'(n_push);
            rd_reg  <= rd_reg + ets_pkg::QPTR_W'(pop);
            cnt_reg <= cnt_reg + ets_pkg::QCNT_W'(n_push) - ets_pkg::QCNT_W'(pop);
        end
    end

endmodule

@@ design/expression_token_scanner_top.sv @@
// Expression token scanner: one character byte per input item, tokens out.
// A byte is taken in every cycle while s_tready is high; its tokens (none,
// one or two) are written into a four-entry output queue and show on m_*
// from the queue registers, in order. A byte that closes a number or name and also starts an
// operator, the end or an invalid token yields two tokens, which leave one
// at a time; s_tready drops while fewer than two queue entries are free.
// Depends on ets_pkg, ets_scan and ets_queue.
module expression_token_scanner_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] token_kind, [6:4] error_code,
                                   // [22:7] token_start, [38:23] token_length
    output logic        m_tlast
);

    ets_pkg::scan_res_t res;
    ets_pkg::token_t    tok;
    logic               take;

    assign take = s_tvalid && s_tready;

    ets_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .byte_in (s_tdata),
        .res     (res)
    );

    ets_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (take),
        .push_res  (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (tok)
    );

    assign m_tdata = {1'b0, tok.length, tok.start, tok.code, tok.kind};
    assign m_tlast = tok.last;

endmodule

@@ bench/ets_token_checker.sv @@
`timescale 1ns / 1ps
// Token checker for expression_token_scanner_top: watches both item channels,
// predicts the tokens of every accepted byte and compares them in arrival order.
// Depends on ets_pkg for widths, token kinds, error codes and mode encodings.
module ets_token_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding,
    output int          tokens_checked
);
    import ets_pkg::*;

    localparam logic [79:0] OP_CHARS = "+-*/^()!,=";

    mode_t                scan_state = MODE_IDLE;
    mark_t                mark_state = MARK_NONE;
    logic [POS_WIDTH-1:0] pos        = '0;
    logic [POS_WIDTH-1:0] tok_start  = '0;
    int unsigned          name_len   = 0;
    token_t               expected_tokens[$];
    int                   fail_total = 0;
    int                   seen       = 0;

    function automatic bit is_num_char(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return (b >= 8'h09 && b <= 8'h0D) || b == 8'h20;
    endfunction

    function automatic bit is_name_lead(input logic [7:0] b);
        return b == "_" || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b >= HIGH_BYTE;
    endfunction

    function automatic logic [3:0] operator_kind(input logic [7:0] b);
        logic [3:0] k;
        k = KIND_INVALID;
        for (int i = 0; i < 10; i++) begin
            if (OP_CHARS[8*(9-i) +: 8] == b) k = KIND_PLUS + 4'(i);
        end
        return k;
    endfunction

    function automatic void push_token(input logic [3:0] kind, input logic [2:0] code,
                                       input logic [POS_WIDTH-1:0] start,
                                       input logic [POS_WIDTH-1:0] len, input logic fin);
        token_t t;
        t.kind   = kind;
        t.code   = code;
        t.start  = start;
        t.length = len;
        t.last   = fin;
        expected_tokens.push_back(t);
    endfunction

    function automatic void restart();
        scan_state = MODE_IDLE;
        mark_state = MARK_NONE;
        pos        = '0;
        tok_start  = '0;
        name_len   = 0;
    endfunction

    function automatic void step_pos();
        if (pos != POS_MAX) pos = pos + 1'b1;
    endfunction

    // terminator as the failing byte ends the string at once
    function automatic void abort_token(input logic [2:0] code,
                                        input logic [POS_WIDTH-1:0] start,
                                        input logic [7:0] b);
        push_token(KIND_INVALID, code, start, '0, 1'b1);
        if (b == BYTE_END) begin
            restart();
        end else begin
            scan_state = MODE_ERROR;
            step_pos();
        end
    endfunction

    function automatic void open_token(input logic [7:0] b);
        logic [3:0] k;
        k = operator_kind(b);
        if (b == BYTE_END) begin
            push_token(KIND_END, ERR_NONE, pos, '0, 1'b1);
            restart();
            return;
        end
        tok_start = pos;
        if (is_blank(b)) begin
            scan_state = MODE_IDLE;
        end else if (is_num_char(b)) begin
            scan_state = MODE_INT;
        end else if (b == ".") begin
            scan_state = MODE_DOT;
        end else if (is_name_lead(b)) begin
            scan_state = MODE_NAME;
            name_len   = 1;
        end else if (k == KIND_INVALID) begin
            abort_token(ERR_UNKNOWN, pos, b);
            return;
        end else begin
            push_token(k, ERR_NONE, pos, '0, 1'b0);
            scan_state = MODE_IDLE;
        end
        step_pos();
    endfunction

    function automatic void close_number(input logic [7:0] b);
        push_token(KIND_NUMBER, ERR_NONE, tok_start, pos - tok_start, 1'b0);
        scan_state = MODE_IDLE;
        open_token(b);
    endfunction

    function automatic void predict_tokens(input logic [7:0] b);
        bit is_e;
        is_e = (b == "e" || b == "E");
        case (mark_state)
            MARK_NONE: begin
                if (b == MARK_B0) begin
                    mark_state = MARK_EF;
                    scan_state = MODE_NAME;
                    tok_start  = pos;
                    name_len   = 1;
                    step_pos();
                    return;
                end
                mark_state = MARK_DONE;
            end
            MARK_EF: begin
                mark_state = (b == MARK_B1) ? MARK_EFBB : MARK_DONE;
            end
            MARK_EFBB: begin
                mark_state = MARK_DONE;
                if (b == MARK_B2) begin
                    scan_state = MODE_IDLE;
                    name_len   = 0;
                    step_pos();
                    return;
                end
            end
            default: ;
        endcase

        case (scan_state)
            MODE_INT: begin
                if (is_num_char(b)) step_pos();
                else if (b == ".") begin scan_state = MODE_FRAC; step_pos(); end
                else if (is_e) begin scan_state = MODE_EXP_E; step_pos(); end
                else close_number(b);
            end
            MODE_DOT: begin
                if (is_num_char(b)) begin scan_state = MODE_FRAC; step_pos(); end
                else abort_token(ERR_NO_DIGITS, tok_start, b);
            end
            MODE_FRAC: begin
                if (is_num_char(b)) step_pos();
                else if (is_e) begin scan_state = MODE_EXP_E; step_pos(); end
                else close_number(b);
            end
            MODE_EXP_E: begin
                if (b == "+" || b == "-") begin scan_state = MODE_EXP_SIGN; step_pos(); end
                else if (is_num_char(b)) begin scan_state = MODE_EXP_DIG; step_pos(); end
                else abort_token(ERR_BARE_EXP, tok_start, b);
            end
            MODE_EXP_SIGN: begin
                if (is_num_char(b)) begin scan_state = MODE_EXP_DIG; step_pos(); end
                else abort_token(ERR_BARE_EXP, tok_start, b);
            end
            MODE_EXP_DIG: begin
                if (is_num_char(b)) step_pos();
                else close_number(b);
            end
            MODE_NAME: begin
                if (is_name_lead(b) || is_num_char(b)) begin
                    if (name_len + 1 >= NAME_BUFFER) begin
                        abort_token(ERR_LONG_NAME, tok_start, b);
                    end else begin
                        name_len++;
                        step_pos();
                    end
                end else begin
                    push_token(KIND_NAME, ERR_NONE, tok_start, POS_WIDTH'(name_len), 1'b0);
                    name_len   = 0;
                    scan_state = MODE_IDLE;
                    open_token(b);
                end
            end
            MODE_ERROR: begin
                if (b == BYTE_END) restart();
                else step_pos();
            end
            default: open_token(b);
        endcase
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_total++;
        end
    endtask

    always @(posedge aclk) begin : watch
        token_t want;
        if (!aresetn) begin
            restart();
            expected_tokens.delete();
        end else begin
            // a token never leaves in the cycle its byte is taken
            if (m_tvalid && m_tready) begin
                seen++;
                if (expected_tokens.size() == 0) begin
                    $error("token_kind: expected none, actual %0d", m_tdata[3:0]);
                    fail_total++;
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", want.kind, m_tdata[3:0]);
                    check_field("error_code", want.code, m_tdata[6:4]);
                    check_field("token_start", want.start, m_tdata[22:7]);
                    check_field("token_length", want.length, m_tdata[38:23]);
                    check_field("last", want.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready) predict_tokens(s_tdata);
        end
        mismatches     <= fail_total;
        outstanding    <= expected_tokens.size();
        tokens_checked <= seen;
    end

endmodule

@@ bench/tb_expression_token_scanner_top.sv @@
`timescale 1ns / 1ps
// Top of the expression token scanner bench: clock, reset, byte stimulus and verdict.
// Depends on ets_pkg, expression_token_scanner_top and ets_token_checker.
module tb_expression_token_scanner_top;
    import ets_pkg::*;

    localparam logic [79:0]  OP_CHARS  = "+-*/^()!,=";
    localparam logic [135:0] ODD_CHARS = "#$%&':;<>?@[]{|}~";

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    int mismatches;
    int outstanding;
    int tokens_checked;
    int bytes_sent   = 0;
    int strings_sent = 0;
    bit s_quiet      = 1'b0;
    bit m_quiet      = 1'b0;

    always #1 aclk = ~aclk;

    expression_token_scanner_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    ets_token_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .tokens_checked (tokens_checked)
    );

    function automatic logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_name_char(input bit lead);
        logic [7:0] b;
        case ($urandom_range(0, lead ? 3 : 4))
            0:       b = "_";
            1:       b = 8'("A" + $urandom_range(0, 25));
            2:       b = 8'("a" + $urandom_range(0, 25));
            3:       b = 8'($urandom_range(128, 255));
            default: b = pick_digit();
        endcase
        return b;
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'(9 + r);
    endfunction

    function automatic logic [7:0] pick_non_digit(input bit no_sign);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while ((b >= "0" && b <= "9") || (no_sign && (b == "+" || b == "-")));
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = s_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (b == BYTE_END) strings_sent++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) send_byte(t[i]);
    endtask

    task automatic send_number();
        int k;
        if ($urandom_range(0, 5) == 0) begin
            send_byte(".");
            repeat ($urandom_range(1, 3)) send_byte(pick_digit());
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(pick_digit());
            if ($urandom_range(0, 2) == 0) begin
                send_byte(".");
                repeat ($urandom_range(0, 3)) send_byte(pick_digit());
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            send_byte($urandom_range(0, 1) ? "e" : "E");
            k = $urandom_range(0, 2);
            if (k == 1) send_byte("+");
            else if (k == 2) send_byte("-");
            repeat ($urandom_range(1, 2)) send_byte(pick_digit());
        end
    endtask

    task automatic send_name(input int n);
        send_byte(pick_name_char(1'b1));
        repeat (n - 1) send_byte(pick_name_char(1'b0));
    endtask

    task automatic send_expression();
        logic [7:0] b;
        int         k;
        s_quiet = ($urandom_range(0, 5) == 0);
        case ($urandom_range(0, 9))
            0: begin
                send_byte(MARK_B0);
                send_byte(MARK_B1);
                send_byte(MARK_B2);
            end
            1: begin
                send_byte(MARK_B0);
                send_byte(8'($urandom_range(0, 255)));
            end
            2: begin
                send_byte(MARK_B0);
                send_byte(MARK_B1);
                send_byte(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) send_byte(pick_blank());
            case ($urandom_range(0, 8))
                0, 1, 2: send_number();
                3, 4:    send_name($urandom_range(1, 6));
                default: send_byte(OP_CHARS[8*$urandom_range(0, 9) +: 8]);
            endcase
        end
        // broken tail; where a blank leads it, the blank keeps it from joining the previous token
        case ($urandom_range(0, 9))
            0: begin
                send_byte(8'h20);
                send_byte(".");
                send_byte(pick_non_digit(1'b0));
            end
            1: begin
                send_byte(8'h20);
                send_byte(pick_digit());
                send_byte("e");
                if ($urandom_range(0, 1)) begin
                    send_byte("-");
                    send_byte(pick_non_digit(1'b0));
                end else begin
                    send_byte(pick_non_digit(1'b1));
                end
            end
            2: begin
                k = $urandom_range(0, 5);
                if (k == 0) b = 8'($urandom_range(1, 8));
                else if (k == 1) b = 8'($urandom_range(14, 31));
                else if (k == 2) b = 8'h7F;
                else b = ODD_CHARS[8*$urandom_range(0, 16) +: 8];
                send_byte(b);
            end
            3: begin
                send_byte(8'h20);
                send_name($urandom_range(62, 66));
            end
            4: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            default: ;
        endcase
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(1, 255)));
        send_byte(BYTE_END);
    endtask

    initial begin : drain_side
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) m_quiet = !m_quiet;
            gap = m_quiet ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // mark, blanks, signed exponent, name with high byte, every operator
        send_byte(MARK_B0);
        send_byte(MARK_B1);
        send_byte(MARK_B2);
        send_text(" 1.5E-3+_z");
        send_byte(8'h80);
        send_text("9");
        send_byte(BYTE_END);
        send_text("-*/^()!,=");
        send_byte(BYTE_END);

        while (bytes_sent < 680) send_expression();
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (outstanding != 0);
        repeat (16) @(posedge aclk);

        $display("Scanned %0d strings (%0d bytes) into %0d checked tokens,", strings_sent,
                 bytes_sent, tokens_checked);
        $display("with marks, blanks, malformed numbers, long names and unknown bytes.");
        if (mismatches == 0) begin
            $display("expression_token_scanner_top verification clean");
        end else begin
            $display("expression_token_scanner_top verification failed");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("expression_token_scanner_top verification failed");
        $finish;
    end

endmodule
